// ----- rtl/core/cvt_pkg.sv -----
`timescale 1ns / 1ps

package cvt_pkg;

	// Fixed rational constants of the CVT CRT-blanking formula
	localparam logic [27:0] NUM_BASE        = 28'd256000000;
	localparam logic [9:0]  MIN_VSYNC_BP_US = 10'd550;
	localparam logic [1:0]  MIN_V_PORCH     = 2'd3;
	localparam logic [2:0]  MIN_V_BPORCH    = 3'd6;
	localparam logic [4:0]  MARGIN_PERMILLE = 5'd18;
	localparam logic [3:0]  HSYNC_PERCENT   = 4'd8;
	localparam logic [7:0]  DUTY_MIN        = 8'd200;
	localparam logic [8:0]  DUTY_OFFSET     = 9'd300;
	localparam logic [1:0]  DUTY_SLOPE      = 2'd3;
	localparam logic [6:0]  PERCENT         = 7'd100;
	localparam logic [9:0]  PERMILLE        = 10'd1000;

	// Vertical sync widths that encode the aspect ratio
	localparam logic [3:0] VS_4_3   = 4'd4;
	localparam logic [3:0] VS_16_9  = 4'd5;
	localparam logic [3:0] VS_16_10 = 4'd6;
	localparam logic [3:0] VS_5_4   = 4'd7;
	localparam logic [3:0] VS_OTHER = 4'd10;

	localparam int RF_W  = 17;
	localparam int NUM_W = 29;
	localparam int DEN_W = 32;
	localparam int P_W   = 40;
	localparam int DVA_W = 41;
	localparam int DM_W  = 42;
	localparam int DVB_W = 47;
	localparam int HP_W  = 54;
	localparam int DVC_W = 48;
	localparam int VQ_W  = 12;
	localparam int HQ_W  = 12;
	localparam int PC_W  = 16;

	typedef struct packed {
		logic [12:0] width_pixels;
		logic [12:0] height_lines;
		logic [15:0] refresh_q8;
		logic        margin_on;
		logic        interlace_on;
	} cvt_mode_t;

	typedef struct packed {
		logic [13:0] h_total;
		logic [13:0] h_active;
		logic [7:0]  h_margin;
		logic [11:0] h_front_porch;
		logic [10:0] h_sync_width;
		logic [11:0] h_back_porch;
		logic [13:0] v_total;
		logic [13:0] v_active;
		logic [7:0]  v_margin;
		logic [3:0]  v_sync_width;
		logic [11:0] v_back_porch;
		logic [15:0] pixel_clock_qmhz;
	} cvt_timing_t;

	typedef struct packed {
		logic [13:0]      hact;
		logic [7:0]       hmargin;
		logic [DEN_W-1:0] den;
		logic [NUM_W-1:0] num;
	} cvt_hside_t;

	typedef struct packed {
		logic [13:0] vact;
		logic [7:0]  vmargin;
		logic [3:0]  vsync;
	} cvt_vside_t;

	typedef struct packed {
		logic [DVA_W-1:0] dva;
		logic [DVB_W-1:0] dvb;
		logic [HP_W-1:0]  hp;
		cvt_hside_t       hs;
		cvt_vside_t       vs;
	} cvt_fe_t;

	typedef struct packed {
		logic [13:0] h_total;
		logic [13:0] h_active;
		logic [7:0]  h_margin;
		logic [10:0] h_sync;
		logic [11:0] h_blank;
		logic [13:0] v_total;
		logic [13:0] v_active;
		logic [7:0]  v_margin;
		logic [3:0]  v_sync;
		logic [11:0] v_bp;
	} cvt_cside_t;

endpackage

// ----- rtl/core/cvt_div.sv -----
`timescale 1ns / 1ps

module cvt_div #(
	parameter int NW = 41,
	parameter int DW = 29,
	parameter int QW = 12,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quot,
	output logic [SW-1:0] side_out
);

	localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic          vld_s  [QW+1];
	logic [NW-1:0] rem_s  [QW+1];
	logic [DW-1:0] dvs_s  [QW+1];
	logic [QW-1:0] q_s    [QW+1];
	logic          ovf_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// quotient that does not fit saturates
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= dividend;
			dvs_s[0]  <= divisor;
			q_s[0]    <= '0;
			ovf_s[0]  <= XW'(dividend) >= (XW'(divisor) << QW);
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		localparam int B = QW - k;
		logic [XW-1:0] trial;
		logic          take;
		logic [QW-1:0] q_nx;

		always_comb begin
			trial   = XW'(dvs_s[k-1]) << B;
			take    = XW'(rem_s[k-1]) >= trial;
			q_nx    = q_s[k-1];
			q_nx[B] = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? NW'(XW'(rem_s[k-1]) - trial) : rem_s[k-1];
				dvs_s[k]  <= dvs_s[k-1];
				q_s[k]    <= q_nx;
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quot      = ovf_s[QW] ? '1 : q_s[QW];
	assign side_out  = side_s[QW];

endmodule

// ----- rtl/core/cvt_front.sv -----
`timescale 1ns / 1ps

module cvt_front #(
	parameter int CELL_SIZE = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  cvt_pkg::cvt_mode_t mode,
	output logic              out_valid,
	output cvt_pkg::cvt_fe_t  fe
);
	import cvt_pkg::*;

	localparam int HB_MUL = 2 * CELL_SIZE;
	// reciprocals for exact floor division by constants over the operand ranges
	localparam longint unsigned CELL_RCP =
		((64'd1 << 17) + 64'(CELL_SIZE) - 64'd1) / 64'(CELL_SIZE);
	localparam longint unsigned PM_RCP =
		((64'd1 << 28) + 64'(PERMILLE) - 64'd1) / 64'(PERMILLE);

	// stage 1: rates, rounded width, field lines, aspect
	logic [15:0]     r_nz;
	logic [RF_W-1:0] rf_c;
	logic [30:0]     wq_prod;
	logic [12:0]     wq_c;
	logic [12:0]     hrnd_c;
	logic [12:0]     vlines_c;
	logic [3:0]      vsync_c;
	logic [16:0]     w3, h4, w9, h16, w10, w4, h5, h15;

	always_comb begin
		r_nz     = (mode.refresh_q8 == 16'd0) ? 16'd1 : mode.refresh_q8;
		rf_c     = mode.interlace_on ? {r_nz, 1'b0} : {1'b0, r_nz};
		wq_prod  = 31'(mode.width_pixels) * 31'(CELL_RCP);
		wq_c     = wq_prod[29:17];
		hrnd_c   = 13'(17'(wq_c) * 17'(CELL_SIZE));
		vlines_c = mode.interlace_on ? {1'b0, mode.height_lines[12:1]} : mode.height_lines;
		w3  = 17'(mode.width_pixels) * 17'd3;
		w4  = 17'(mode.width_pixels) * 17'd4;
		w9  = 17'(mode.width_pixels) * 17'd9;
		w10 = 17'(mode.width_pixels) * 17'd10;
		h4  = 17'(mode.height_lines) * 17'd4;
		h5  = 17'(mode.height_lines) * 17'd5;
		h15 = 17'(mode.height_lines) * 17'd15;
		h16 = 17'(mode.height_lines) * 17'd16;
		priority if (w3 == h4)                vsync_c = VS_4_3;
		else if (w9 == h16)                   vsync_c = VS_16_9;
		else if (w10 == h16)                  vsync_c = VS_16_10;
		else if (w4 == h5 || w9 == h15)       vsync_c = VS_5_4;
		else                                  vsync_c = VS_OTHER;
	end

	logic            vld_s1;
	logic [RF_W-1:0] rf_s1;
	logic [12:0]     hrnd_s1, vlines_s1, wq_s1;
	logic            mg_s1, il_s1;
	logic [3:0]      vsync_s1;

	// stage 2: margins, active sizes, numerator of the line period
	// the cell size cancels, so the side margin is taken from the cell count
	logic [17:0]      hm_prod, vm_prod;
	logic [36:0]      hm_rcp, vm_rcp;
	logic [7:0]       hmargin_c, vmargin_c;
	logic [13:0]      hact_c, vact_c;
	logic [NUM_W-1:0] num_c;

	always_comb begin
		hm_prod   = 18'(wq_s1) * 18'(MARGIN_PERMILLE);
		vm_prod   = 18'(vlines_s1) * 18'(MARGIN_PERMILLE);
		hm_rcp    = 37'(hm_prod) * 37'(PM_RCP);
		vm_rcp    = 37'(vm_prod) * 37'(PM_RCP);
		hmargin_c = mg_s1 ? 8'(12'(hm_rcp[35:28]) * 12'(CELL_SIZE)) : 8'd0;
		vmargin_c = mg_s1 ? vm_rcp[35:28] : 8'd0;
		hact_c    = 14'(hrnd_s1) + 14'({hmargin_c, 1'b0});
		vact_c    = 14'(vlines_s1) + 14'({vmargin_c, 1'b0});
		num_c     = {NUM_BASE - 28'(rf_s1) * 28'(MIN_VSYNC_BP_US), 1'b0};
	end

	logic             vld_s2;
	logic [RF_W-1:0]  rf_s2;
	logic             il_s2;
	logic [3:0]       vsync_s2;
	logic [13:0]      hact_s2, vact_s2;
	logic [7:0]       hmargin_s2, vmargin_s2;
	logic [NUM_W-1:0] num_s2;

	// stage 3: denominator
	logic [14:0]      lines_c;
	logic [DEN_W-1:0] den_c;

	always_comb begin
		lines_c = {vact_s2, 1'b0} + 15'(MIN_V_PORCH) + 15'(MIN_V_PORCH) + 15'(il_s2);
		den_c   = 32'(rf_s2) * 32'(lines_c);
	end

	logic             vld_s3;
	cvt_hside_t       hs_s3;
	cvt_vside_t       vs_s3;

	// stage 4: blanking duty, clamped at the floor
	logic [30:0]    three_num;
	logic [P_W-1:0] hundred_den, p_c;

	always_comb begin
		three_num   = 31'(hs_s3.num) * 31'(DUTY_SLOPE);
		hundred_den = P_W'(hs_s3.den) * P_W'(PERCENT);
		if (P_W'(three_num) > hundred_den) begin
			p_c = P_W'(hs_s3.den) * P_W'(DUTY_MIN);
		end else begin
			p_c = P_W'(hs_s3.den) * P_W'(DUTY_OFFSET) - P_W'(three_num);
		end
	end

	logic           vld_s4;
	cvt_hside_t     hs_s4;
	cvt_vside_t     vs_s4;
	logic [P_W-1:0] p_s4;

	// stage 5: partial products and blanking divisor
	logic [33:0]      hp_lo_c, hp_hi_c;
	logic [DM_W-1:0]  dm_c;
	logic [DVA_W-1:0] dva_c;

	always_comb begin
		hp_lo_c = 34'(hs_s4.hact) * 34'(p_s4[19:0]);
		hp_hi_c = 34'(hs_s4.hact) * 34'(p_s4[P_W-1:20]);
		dm_c    = DM_W'(hs_s4.den) * DM_W'(PERMILLE) - DM_W'(p_s4);
		dva_c   = DVA_W'(hs_s4.den) * DVA_W'(MIN_VSYNC_BP_US);
	end

	logic             vld_s5;
	cvt_hside_t       hs_s5;
	cvt_vside_t       vs_s5;
	logic [33:0]      hp_lo_s5, hp_hi_s5;
	logic [DM_W-1:0]  dm_s5;
	logic [DVA_W-1:0] dva_s5;

	// stage 6: join the product, scale divisor by two cells
	cvt_fe_t fe_c;

	always_comb begin
		fe_c.dva = dva_s5;
		fe_c.dvb = DVB_W'(dm_s5) * DVB_W'(HB_MUL);
		fe_c.hp  = (HP_W'(hp_hi_s5) << 20) + HP_W'(hp_lo_s5);
		fe_c.hs  = hs_s5;
		fe_c.vs  = vs_s5;
	end

	logic    vld_s6;
	cvt_fe_t fe_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rf_s1      <= rf_c;
			hrnd_s1    <= hrnd_c;
			wq_s1      <= wq_c;
			vlines_s1  <= vlines_c;
			mg_s1      <= mode.margin_on;
			il_s1      <= mode.interlace_on;
			vsync_s1   <= vsync_c;

			rf_s2      <= rf_s1;
			il_s2      <= il_s1;
			vsync_s2   <= vsync_s1;
			hact_s2    <= hact_c;
			vact_s2    <= vact_c;
			hmargin_s2 <= hmargin_c;
			vmargin_s2 <= vmargin_c;
			num_s2     <= num_c;

			hs_s3.hact    <= hact_s2;
			hs_s3.hmargin <= hmargin_s2;
			hs_s3.den     <= den_c;
			hs_s3.num     <= num_s2;
			vs_s3.vact    <= vact_s2;
			vs_s3.vmargin <= vmargin_s2;
			vs_s3.vsync   <= vsync_s2;

			hs_s4 <= hs_s3;
			vs_s4 <= vs_s3;
			p_s4  <= p_c;

			hs_s5    <= hs_s4;
			vs_s5    <= vs_s4;
			hp_lo_s5 <= hp_lo_c;
			hp_hi_s5 <= hp_hi_c;
			dm_s5    <= dm_c;
			dva_s5   <= dva_c;

			fe_s6 <= fe_c;
		end
	end

	assign out_valid = vld_s6;
	assign fe        = fe_s6;

endmodule

// ----- rtl/core/cvt_video_timing_calc.sv -----
// CVT CRT-blanking timing calculator.
// Mode channel (mode_valid / mode_stall / mode): one requested video mode per
// transfer. Timing channel (timing_valid / timing_stall / timing): one result
// per mode, in order.
// The path holds 38 register stages from a mode transfer to timing_valid: six
// front stages (rates, margins, line-period denominator, duty cycle, products,
// product join), two parallel 13-stage restoring dividers (vertical sync+back
// porch and horizontal blanking, an input stage and then one quotient bit per
// stage), one stage for totals, a 17-stage divider for the pixel clock, and the
// output register.
// Throughput is one mode per cycle while mode_stall is low; every stage advances together.
// When timing_stall holds a result, the next finished item drops into a skid
// register; while that register is full the pipeline freezes and mode_stall is
// high. mode_stall comes from a register, not from timing_stall.
// Reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps

module cvt_video_timing_calc #(
	parameter int CELL_SIZE = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mode_valid,
	output logic                 mode_stall,
	input  cvt_pkg::cvt_mode_t   mode,
	output logic                 timing_valid,
	input  logic                 timing_stall,
	output cvt_pkg::cvt_timing_t timing
);
	import cvt_pkg::*;

	localparam int HB_MUL = 2 * CELL_SIZE;
	localparam int HS_DIV = 100 * CELL_SIZE;
	// reciprocal for an exact floor division of the sync product
	localparam longint unsigned HS_RCP =
		((64'd1 << 28) + 64'(HS_DIV) - 64'd1) / 64'(HS_DIV);

	logic        en;
	logic        fe_valid;
	cvt_fe_t     fe;
	logic        a_valid, b_valid;
	logic [VQ_W-1:0] vq;
	logic [HQ_W-1:0] hq;
	cvt_vside_t  a_side;
	cvt_hside_t  b_side;

	cvt_front #(.CELL_SIZE(CELL_SIZE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (mode_valid),
		.mode     (mode),
		.out_valid(fe_valid),
		.fe       (fe)
	);

	cvt_div #(.NW(DVA_W), .DW(NUM_W), .QW(VQ_W), .SW($bits(cvt_vside_t))) u_div_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fe_valid),
		.dividend (fe.dva),
		.divisor  (fe.hs.num),
		.side_in  (fe.vs),
		.out_valid(a_valid),
		.quot     (vq),
		.side_out (a_side)
	);

	cvt_div #(.NW(HP_W), .DW(DVB_W), .QW(HQ_W), .SW($bits(cvt_hside_t))) u_div_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fe_valid),
		.dividend (fe.hp),
		.divisor  (fe.dvb),
		.side_in  (fe.hs),
		.out_valid(b_valid),
		.quot     (hq),
		.side_out (b_side)
	);

	// totals and vertical back porch
	logic [12:0] vsbp_q1, vsbp_min, vsbp_c, vbp_diff;
	logic [14:0] vtot_sum;
	logic [11:0] hblank_c;
	cvt_cside_t  side7_c;

	always_comb begin
		vsbp_q1  = 13'(vq) + 13'd1;
		vsbp_min = 13'(a_side.vsync) + 13'(MIN_V_BPORCH);
		vsbp_c   = (vsbp_q1 < vsbp_min) ? vsbp_min : vsbp_q1;
		vbp_diff = vsbp_c - 13'(a_side.vsync);
		vtot_sum = 15'(a_side.vact) + 15'(vsbp_c) + 15'(MIN_V_PORCH);
		hblank_c = 12'(17'(hq) * 17'(HB_MUL));

		side7_c.h_total  = b_side.hact + 14'(hblank_c);
		side7_c.h_active = b_side.hact;
		side7_c.h_margin = b_side.hmargin;
		side7_c.h_sync   = '0;
		side7_c.h_blank  = hblank_c;
		side7_c.v_total  = vtot_sum[14] ? 14'h3FFF : vtot_sum[13:0];
		side7_c.v_active = a_side.vact;
		side7_c.v_margin = a_side.vmargin;
		side7_c.v_sync   = a_side.vsync;
		side7_c.v_bp     = vbp_diff[12] ? 12'hFFF : vbp_diff[11:0];
	end

	logic             vld_s7;
	cvt_cside_t       side_s7;
	logic [DEN_W-1:0] den_s7;
	logic [NUM_W-1:0] num_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= a_valid & b_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side7_c;
			den_s7  <= b_side.den;
			num_s7  <= b_side.num;
		end
	end

	// sync width and pixel clock dividend
	logic [16:0]      hs_prod;
	logic [38:0]      hs_rcp;
	cvt_cside_t       side_c_in;
	logic [DVC_W-1:0] dvc;

	always_comb begin
		hs_prod          = 17'(side_s7.h_total) * 17'(HSYNC_PERCENT);
		hs_rcp           = 39'(hs_prod) * 39'(HS_RCP);
		side_c_in        = side_s7;
		side_c_in.h_sync = 11'(15'(hs_rcp[38:28]) * 15'(CELL_SIZE));
		dvc              = (DVC_W'(side_s7.h_total) * DVC_W'(den_s7)) << 2;
	end

	logic            c_valid;
	logic [PC_W-1:0] pclk;
	cvt_cside_t      c_side;

	cvt_div #(.NW(DVC_W), .DW(NUM_W), .QW(PC_W), .SW($bits(cvt_cside_t))) u_div_pclk (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s7),
		.dividend (dvc),
		.divisor  (num_s7),
		.side_in  (side_c_in),
		.out_valid(c_valid),
		.quot     (pclk),
		.side_out (c_side)
	);

	// porch split and result assembly
	logic [11:0] hbp_c, hrest_c;
	cvt_timing_t res_c;

	always_comb begin
		hbp_c   = {1'b0, c_side.h_blank[11:1]};
		hrest_c = c_side.h_blank - hbp_c;
		res_c.h_total          = c_side.h_total;
		res_c.h_active         = c_side.h_active;
		res_c.h_margin         = c_side.h_margin;
		res_c.h_front_porch    = (hrest_c > 12'(c_side.h_sync)) ?
		                         hrest_c - 12'(c_side.h_sync) : 12'd0;
		res_c.h_sync_width     = c_side.h_sync;
		res_c.h_back_porch     = hbp_c;
		res_c.v_total          = c_side.v_total;
		res_c.v_active         = c_side.v_active;
		res_c.v_margin         = c_side.v_margin;
		res_c.v_sync_width     = c_side.v_sync;
		res_c.v_back_porch     = c_side.v_bp;
		res_c.pixel_clock_qmhz = pclk;
	end

	// output register with skid
	logic        out_valid_q, skid_valid_q;
	cvt_timing_t out_q, skid_q;
	logic        out_take;

	assign en       = !skid_valid_q;
	assign out_take = out_valid_q && !timing_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_take) begin
			out_valid_q <= c_valid;
		end else if (c_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || out_take) begin
			if (c_valid) begin
				out_q <= res_c;
			end
		end else if (c_valid) begin
			skid_q <= res_c;
		end
	end

	assign mode_stall   = skid_valid_q;
	assign timing_valid = out_valid_q;
	assign timing       = out_q;

endmodule

// ----- rtl/core/cvt_chk.sv -----
`timescale 1ns / 1ps

module cvt_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 mode_valid,
	input logic                 mode_stall,
	input cvt_pkg::cvt_mode_t   mode,
	input logic                 timing_valid,
	input logic                 timing_stall,
	input cvt_pkg::cvt_timing_t timing
);
	import cvt_pkg::*;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		timing_valid && timing_stall |=> timing_valid && $stable(timing))
		else $error("stalled result changed");

	a_vsync: assert property (@(posedge clk) disable iff (!arst_n)
		timing_valid |-> (timing.v_sync_width == VS_4_3 ||
		timing.v_sync_width == VS_16_9 || timing.v_sync_width == VS_16_10 ||
		timing.v_sync_width == VS_5_4 || timing.v_sync_width == VS_OTHER))
		else $error("bad vertical sync width");

	// blanking is an even count, split in two equal halves
	a_htotal: assert property (@(posedge clk) disable iff (!arst_n)
		timing_valid |-> 15'(timing.h_total) ==
		15'(timing.h_active) + 15'({timing.h_back_porch, 1'b0}))
		else $error("horizontal total does not match blanking");

	a_hfp: assert property (@(posedge clk) disable iff (!arst_n)
		timing_valid |-> (timing.h_front_porch == 12'd0 ||
		13'(timing.h_front_porch) + 13'(timing.h_sync_width) ==
		13'(timing.h_back_porch)))
		else $error("front porch inconsistent with sync");

endmodule

bind cvt_video_timing_calc cvt_chk u_cvt_chk (.*);

// ----- tb/tb_cvt_video_timing_calc.sv -----
`timescale 1ns / 1ps

module tb_cvt_video_timing_calc;
	import cvt_pkg::*;

	localparam int CELL = 8;
	localparam int LATENCY = 38;
	localparam longint CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        mode_valid;
	logic        mode_stall;
	cvt_mode_t   mode;
	logic        timing_valid;
	logic        timing_stall;
	cvt_timing_t timing;

	int     error_count = 0;
	longint cycle_count = 0;
	bit     long_hold_req;
	bit     sink_done;

	cvt_video_timing_calc #(.CELL_SIZE(CELL)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.mode_valid(mode_valid),
		.mode_stall(mode_stall),
		.mode(mode),
		.timing_valid(timing_valid),
		.timing_stall(timing_stall),
		.timing(timing)
	);

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	function automatic logic [3:0] vsync_for_aspect(longint unsigned w, longint unsigned h);
		if (w * 3 == h * 4) return VS_4_3;
		if (w * 9 == h * 16) return VS_16_9;
		if (w * 10 == h * 16) return VS_16_10;
		if (w * 4 == h * 5) return VS_5_4;
		if (w * 9 == h * 15) return VS_5_4;
		return VS_OTHER;
	endfunction

	function automatic cvt_timing_t compute_timing(cvt_mode_t m);
		longint unsigned w, h, r, mg, il, rf, hrnd, hmar, hact, vlines, vmar, vact;
		longint unsigned vs, num, den, vsbp, vbp, vtot, p, hblank, htot, hsync, hbp;
		longint unsigned hfp, pclk;
		cvt_timing_t t;
		w = m.width_pixels;
		h = m.height_lines;
		r = m.refresh_q8;
		mg = m.margin_on;
		il = m.interlace_on;
		if (r == 0) r = 1;
		rf = il ? 2 * r : r;
		hrnd = (w / CELL) * CELL;
		hmar = mg ? (hrnd * 18 / (1000 * CELL)) * CELL : 0;
		hact = hrnd + 2 * hmar;
		vlines = il ? h / 2 : h;
		vmar = mg ? vlines * 18 / 1000 : 0;
		vact = vlines + 2 * vmar;
		vs = vsync_for_aspect(w, h);
		num = 2 * (256000000 - 550 * rf);
		den = rf * (2 * vact + 6 + il);
		vsbp = 550 * den / num + 1;
		if (vsbp < vs + 6) vsbp = vs + 6;
		vbp = vsbp - vs;
		if (vbp > 4095) vbp = 4095;
		vtot = vact + vsbp + 3;
		if (vtot > 16383) vtot = 16383;
		if (3 * num > 100 * den) p = 200 * den;
		else p = 300 * den - 3 * num;
		hblank = (hact * p / ((1000 * den - p) * 2 * CELL)) * 2 * CELL;
		htot = hact + hblank;
		hsync = (8 * htot / (100 * CELL)) * CELL;
		hbp = hblank / 2;
		hfp = (hblank - hbp > hsync) ? hblank - hbp - hsync : 0;
		pclk = 4 * htot * den / num;
		if (pclk > 65535) pclk = 65535;
		t.h_total = htot[13:0];
		t.h_active = hact[13:0];
		t.h_margin = hmar[7:0];
		t.h_front_porch = hfp[11:0];
		t.h_sync_width = hsync[10:0];
		t.h_back_porch = hbp[11:0];
		t.v_total = vtot[13:0];
		t.v_active = vact[13:0];
		t.v_margin = vmar[7:0];
		t.v_sync_width = vs[3:0];
		t.v_back_porch = vbp[11:0];
		t.pixel_clock_qmhz = pclk[15:0];
		return t;
	endfunction

	class timing_scoreboard;
		cvt_timing_t pending_timings[$];

		function void note_mode(cvt_mode_t m);
			pending_timings.push_back(compute_timing(m));
		endfunction

		task check_timing(cvt_timing_t got);
			cvt_timing_t want;
			if (pending_timings.size() == 0) begin
				$display("ERROR %0t: timing transfer with nothing pending", $time);
				error_count++;
				return;
			end
			want = pending_timings.pop_front();
			if (got.h_total != want.h_total)
				report_mismatch("h_total", got.h_total, want.h_total);
			if (got.h_active != want.h_active)
				report_mismatch("h_active", got.h_active, want.h_active);
			if (got.h_margin != want.h_margin)
				report_mismatch("h_margin", got.h_margin, want.h_margin);
			if (got.h_front_porch != want.h_front_porch)
				report_mismatch("h_front_porch", got.h_front_porch, want.h_front_porch);
			if (got.h_sync_width != want.h_sync_width)
				report_mismatch("h_sync_width", got.h_sync_width, want.h_sync_width);
			if (got.h_back_porch != want.h_back_porch)
				report_mismatch("h_back_porch", got.h_back_porch, want.h_back_porch);
			if (got.v_total != want.v_total)
				report_mismatch("v_total", got.v_total, want.v_total);
			if (got.v_active != want.v_active)
				report_mismatch("v_active", got.v_active, want.v_active);
			if (got.v_margin != want.v_margin)
				report_mismatch("v_margin", got.v_margin, want.v_margin);
			if (got.v_sync_width != want.v_sync_width)
				report_mismatch("v_sync_width", got.v_sync_width, want.v_sync_width);
			if (got.v_back_porch != want.v_back_porch)
				report_mismatch("v_back_porch", got.v_back_porch, want.v_back_porch);
			if (got.pixel_clock_qmhz != want.pixel_clock_qmhz)
				report_mismatch("pixel_clock_qmhz", got.pixel_clock_qmhz,
					want.pixel_clock_qmhz);
		endtask
	endclass

	timing_scoreboard sb;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Send one mode after a random gap unless no_gap is set; hold it until the transfer.
	task automatic send_mode(cvt_mode_t m, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			mode_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode_valid <= 1'b1;
		mode <= m;
		do @(posedge clk); while (mode_stall);
		sb.note_mode(m);
	endtask

	// Drop the valid after the last transfer of a run of modes.
	task automatic idle_mode();
		mode_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cvt_mode_t make_mode(int w, int h, int r, bit mg, bit il);
		cvt_mode_t m;
		m.width_pixels = 13'(w);
		m.height_lines = 13'(h);
		m.refresh_q8 = 16'(r);
		m.margin_on = mg;
		m.interlace_on = il;
		return m;
	endfunction

	function automatic cvt_mode_t random_mode();
		int h, w, r;
		case ($urandom_range(0, 5))
			0: begin
				// well-known aspect ratios at common rates
				h = $urandom_range(2, 1800);
				case ($urandom_range(0, 4))
					0: w = h * 4 / 3;
					1: w = h * 16 / 9;
					2: w = h * 16 / 10;
					3: w = h * 5 / 4;
					default: w = h * 15 / 9;
				endcase
				if (w > 8191) w = 8191;
				r = $urandom_range(50, 120) * 256 + $urandom_range(0, 255);
			end
			1: begin
				w = $urandom_range(8, 8191);
				h = $urandom_range(2, 8191);
				r = $urandom_range(256, 65535);
			end
			2: begin
				w = $urandom_range(8, 2000);
				h = $urandom_range(2, 64);
				r = $urandom_range(256, 2000);
			end
			default: begin
				w = $urandom_range(320, 4096);
				h = $urandom_range(200, 2400);
				r = $urandom_range(24 * 256, 240 * 256);
			end
		endcase
		return make_mode(w, h, r, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	// Receiver: random stalls plus one long hold-off on request.
	initial begin
		int gap;
		bit long_hold_done;
		long_hold_done = 1'b0;
		timing_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_done) begin
				timing_stall <= 1'b0;
			end else if (long_hold_req && !long_hold_done) begin
				timing_stall <= 1'b1;
				repeat (200) @(posedge clk);
				long_hold_done = 1'b1;
				timing_stall <= 1'b0;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				if (gap > 0) begin
					timing_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
				timing_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && timing_valid && !timing_stall) sb.check_timing(timing);
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int wait_cycles;
		bit burst;
		sb = new();
		long_hold_req = 1'b0;
		sink_done = 1'b0;
		arst_n = 1'b0;
		mode_valid = 1'b0;
		mode = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_mode(make_mode(640, 480, 60 * 256, 0, 0), 0);
		send_mode(make_mode(1920, 1080, 60 * 256, 0, 0), 0);
		send_mode(make_mode(1280, 800, 60 * 256, 1, 0), 0);
		send_mode(make_mode(1280, 1024, 75 * 256, 0, 1), 0);
		send_mode(make_mode(1500, 900, 85 * 256, 1, 1), 0);
		send_mode(make_mode(8191, 8191, 65535, 1, 1), 0);
		send_mode(make_mode(8191, 8191, 256, 1, 1), 0);
		send_mode(make_mode(8, 2, 256, 0, 0), 0);
		send_mode(make_mode(8, 2, 65535, 1, 1), 0);
		send_mode(make_mode(0, 0, 0, 0, 0), 0);
		send_mode(make_mode(7, 480, 60 * 256, 1, 0), 0);
		send_mode(make_mode(1000, 0, 60 * 256, 0, 1), 0);
		send_mode(make_mode(8000, 3, 65535, 0, 0), 0);
		send_mode(make_mode(8191, 8191, 1, 0, 0), 0);
		send_mode(make_mode(4096, 8191, 65535, 1, 0), 0);
		send_mode(make_mode(5461, 4096, 24 * 256, 1, 1), 0);
		send_mode(make_mode(8191, 1, 30000, 1, 0), 0);

		// Fill the pipeline behind a long receiver hold-off.
		long_hold_req = 1'b1;
		repeat (80) send_mode(random_mode(), 1);

		for (int i = 0; i < 1700; i++) begin
			if (i == 800) begin
				// Pause until everything has drained.
				idle_mode();
				wait_cycles = 0;
				while (sb.pending_timings.size() != 0 && wait_cycles < 20000) begin
					@(posedge clk);
					wait_cycles++;
				end
			end
			burst = (i % 200) < 40;
			send_mode(random_mode(), burst);
		end

		idle_mode();
		sink_done = 1'b1;
		wait_cycles = 0;
		while (sb.pending_timings.size() != 0 && wait_cycles < 50000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.pending_timings.size() != 0) begin
			$display("ERROR: %0d timings never arrived", sb.pending_timings.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
